>>> rtl/core/three_axis_step_ramp_generator_top_defines.svh
// Assertion macros shared by the checker.
`ifndef THREE_AXIS_STEP_RAMP_GENERATOR_TOP_DEFINES_SVH
`define THREE_AXIS_STEP_RAMP_GENERATOR_TOP_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define TSR_ASSERT_IMP(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define TSR_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

>>> rtl/core/tsr_pkg.sv
`timescale 1ns / 1ps
package tsr_pkg;
  localparam int STEP_WIDTH_DEF = 24;
  localparam int PERIOD_WIDTH_DEF = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE = 2'd2;
  localparam logic [15:0] MAX_SPEED_RST = 16'd1000;
  localparam logic [23:0] ACCEL_RST = 24'd1000;
  localparam logic [23:0] TIME_SCALE_RST = 24'd1000000;
  localparam int NUM_W = 64;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD_DIV, ST_LOAD_WAIT, ST_LOAD_CDIV, ST_LOAD_CWAIT,
    ST_RAMP_DIV, ST_RAMP_WAIT, ST_SQRT, ST_SQRT_WAIT, ST_OUT
  } state_t;

  typedef enum logic [0:0] { OP_DIV, OP_SQRT } op_t;

  typedef struct packed {
    logic start;
    op_t op;
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;
endpackage

>>> rtl/core/tsr_stream_if.sv
`timescale 1ns / 1ps
interface tsr_stream_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/tsr_arith_unit.sv
`timescale 1ns / 1ps
// Shared restoring unit: 64/64 division or 64-bit integer square root,
// one quotient or root bit per cycle.
module tsr_arith_unit (
  input  logic clk,
  input  logic rst,
  input  tsr_pkg::unit_cmd_t cmd,
  input  logic [tsr_pkg::NUM_W-1:0] a,
  input  logic [tsr_pkg::NUM_W-1:0] b,
  output tsr_pkg::unit_stat_t stat,
  output logic [tsr_pkg::NUM_W-1:0] res
);
  localparam int W = tsr_pkg::NUM_W;
  logic [W-1:0] rem, quo, den, bitv, val, root;
  logic [6:0] cnt;
  tsr_pkg::op_t op;
  logic busy;
  logic done;
  logic [W:0] trial;
  logic [W-1:0] rem_sh;
  logic [W-1:0] sq_sum;

  always_comb begin
    rem_sh = {rem[W-2:0], quo[W-1]};
    trial = {1'b0, rem_sh} - {1'b0, den};
    sq_sum = root + bitv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op <= tsr_pkg::OP_DIV;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        op <= cmd.op;
        cnt <= 7'(W);
        rem <= '0;
        quo <= a;
        den <= b;
        val <= a;
        root <= '0;
        bitv <= {2'b01, {(W-2){1'b0}}};
      end else if (busy) begin
        if (op == tsr_pkg::OP_DIV) begin
          if (!trial[W]) begin
            rem <= trial[W-1:0];
            quo <= {quo[W-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[W-2:0], 1'b0};
          end
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          if (val >= sq_sum) begin
            val <= val - sq_sum;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end
  // After a division res shows the quotient; after a square root, the root.
  assign res = (op == tsr_pkg::OP_DIV) ? quo : root;
  assign stat = '{busy: busy, done: done};
endmodule

>>> rtl/core/tsr_seq.sv
`timescale 1ns / 1ps
module tsr_seq #(
  parameter int STEP_WIDTH = tsr_pkg::STEP_WIDTH_DEF,
  parameter int PERIOD_WIDTH = tsr_pkg::PERIOD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [tsr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tsr_pkg::CFG_DATA_W-1:0] cfg_data,
  tsr_stream_if.sink in_ch,
  tsr_stream_if.source out_ch
);
  localparam int W = tsr_pkg::NUM_W;
  localparam logic [PERIOD_WIDTH-1:0] PMAX = '1;
  localparam int IW = 1 + 3*STEP_WIDTH + 3;

  logic [15:0] max_speed;
  logic [23:0] accel, time_scale;
  logic [STEP_WIDTH-1:0] cnt [3];
  logic [2:0] dirs;
  logic [STEP_WIDTH-1:0] longest, half, slot, ramp_end;
  logic [STEP_WIDTH:0] decel_start;
  logic [PERIOD_WIDTH-1:0] held;
  logic active;
  logic signed [STEP_WIDTH+1:0] err [3];
  logic signed [STEP_WIDTH+1:0] err_dn [3];
  logic [2:0] pulses;
  logic last, idle_r;

  tsr_pkg::state_t state, state_next;
  tsr_pkg::unit_cmd_t ucmd;
  tsr_pkg::unit_stat_t ustat;
  logic [W-1:0] ua, ub, ures, uq;
  logic [STEP_WIDTH:0] m_val;
  logic [STEP_WIDTH+25:0] ramp_x;
  logic [31:0] sp_sq;
  logic [47:0] ts_sq;
  logic [STEP_WIDTH-1:0] c_in [3];
  logic [STEP_WIDTH-1:0] lg_in;
  logic [STEP_WIDTH:0] i_next;
  logic [IW-1:0] d;

  assign d = in_ch.data;
  assign c_in[0] = d[2*STEP_WIDTH+3 +: STEP_WIDTH];
  assign c_in[1] = d[STEP_WIDTH+3 +: STEP_WIDTH];
  assign c_in[2] = d[3 +: STEP_WIDTH];

  always_comb begin
    lg_in = c_in[0];
    if (c_in[1] > lg_in) lg_in = c_in[1];
    if (c_in[2] > lg_in) lg_in = c_in[2];
  end

  always_comb begin
    for (int a = 0; a < 3; a++)
      err_dn[a] = err[a] - $signed((STEP_WIDTH+2)'(cnt[a]));
  end

  tsr_arith_unit u_arith (.clk(clk), .rst(rst), .cmd(ucmd), .a(ua), .b(ub),
    .stat(ustat), .res(ures));

  assign uq = ures;

  // The slot register already holds the current slot once the ramp math runs.
  always_comb begin
    if (slot <= ramp_end)
      m_val = {1'b0, slot};
    else
      m_val = {1'b0, longest} - {1'b0, slot} + 1'b1;
    ramp_x = {accel, 1'b0} * m_val;
    sp_sq = max_speed * max_speed;
    ts_sq = time_scale * time_scale;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tsr_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ucmd = '{start: 1'b0, op: tsr_pkg::OP_DIV};
    ua = '0;
    ub = '0;
    i_next = {1'b0, slot} + 1'b1;
    unique case (state)
      tsr_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          if (!d[IW-1]) state_next = tsr_pkg::ST_LOAD_DIV;
          else if (!active) state_next = tsr_pkg::ST_OUT;
          else if (ramp_end != '0 && (i_next <= {1'b0, ramp_end} ||
                   i_next >= decel_start)) state_next = tsr_pkg::ST_RAMP_DIV;
          else state_next = tsr_pkg::ST_OUT;
        end
      end
      tsr_pkg::ST_LOAD_DIV: begin
        ucmd = '{start: 1'b1, op: tsr_pkg::OP_DIV};
        ua = W'(sp_sq);
        ub = W'({accel, 1'b0});
        state_next = tsr_pkg::ST_LOAD_WAIT;
      end
      tsr_pkg::ST_LOAD_WAIT: if (ustat.done) state_next = tsr_pkg::ST_LOAD_CDIV;
      tsr_pkg::ST_LOAD_CDIV: begin
        ucmd = '{start: 1'b1, op: tsr_pkg::OP_DIV};
        ua = W'(time_scale);
        ub = W'(max_speed);
        state_next = tsr_pkg::ST_LOAD_CWAIT;
      end
      tsr_pkg::ST_LOAD_CWAIT: if (ustat.done) state_next = tsr_pkg::ST_IDLE;
      tsr_pkg::ST_RAMP_DIV: begin
        ucmd = '{start: 1'b1, op: tsr_pkg::OP_DIV};
        ua = W'(ts_sq);
        ub = W'(ramp_x);
        state_next = tsr_pkg::ST_RAMP_WAIT;
      end
      tsr_pkg::ST_RAMP_WAIT: if (ustat.done) state_next = tsr_pkg::ST_SQRT;
      tsr_pkg::ST_SQRT: begin
        ucmd = '{start: 1'b1, op: tsr_pkg::OP_SQRT};
        ua = uq;
        state_next = tsr_pkg::ST_SQRT_WAIT;
      end
      tsr_pkg::ST_SQRT_WAIT: if (ustat.done) state_next = tsr_pkg::ST_OUT;
      tsr_pkg::ST_OUT: if (out_ch.ready) state_next = tsr_pkg::ST_IDLE;
      default: state_next = tsr_pkg::ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state == tsr_pkg::ST_IDLE);
  assign out_ch.valid = (state == tsr_pkg::ST_OUT);
  assign out_ch.data = {pulses, dirs, held & {PERIOD_WIDTH{!idle_r}}, last, idle_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= tsr_pkg::MAX_SPEED_RST;
      accel <= tsr_pkg::ACCEL_RST;
      time_scale <= tsr_pkg::TIME_SCALE_RST;
      active <= 1'b0;
      dirs <= '0;
      held <= '0;
      slot <= '0;
      ramp_end <= '0;
      decel_start <= '0;
      longest <= '0;
      half <= '0;
      for (int a = 0; a < 3; a++) begin
        cnt[a] <= '0;
        err[a] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          tsr_pkg::REG_MAX_SPEED: max_speed <= cfg_data[15:0];
          tsr_pkg::REG_ACCEL: accel <= cfg_data;
          tsr_pkg::REG_TIME_SCALE: time_scale <= cfg_data;
          default: ;
        endcase
      end
      if (state == tsr_pkg::ST_IDLE && in_ch.valid) begin
        if (!d[IW-1]) begin
          for (int a = 0; a < 3; a++) begin
            cnt[a] <= c_in[a];
            err[a] <= (STEP_WIDTH+2)'(lg_in);
          end
          dirs <= d[2:0];
          longest <= lg_in;
          half <= lg_in >> 1;
          slot <= '0;
          active <= (lg_in != '0);
        end else if (!active) begin
          pulses <= '0;
          last <= 1'b0;
          idle_r <= 1'b1;
        end else begin
          idle_r <= 1'b0;
          slot <= i_next[STEP_WIDTH-1:0];
          last <= (i_next >= {1'b0, longest});
          if (i_next >= {1'b0, longest}) active <= 1'b0;
          for (int a = 0; a < 3; a++) begin
            if (err_dn[a] <= $signed((STEP_WIDTH+2)'(half))) begin
              err[a] <= err_dn[a] + $signed((STEP_WIDTH+2)'(longest));
              pulses[2-a] <= 1'b1;
            end else begin
              err[a] <= err_dn[a];
              pulses[2-a] <= 1'b0;
            end
          end
        end
      end
      if (state == tsr_pkg::ST_LOAD_WAIT && ustat.done) begin
        if (accel == '0) ramp_end <= '0;
        else if (uq > W'(half)) ramp_end <= half;
        else ramp_end <= uq[STEP_WIDTH-1:0];
      end
      if (state == tsr_pkg::ST_LOAD_CDIV)
        decel_start <= {1'b0, longest} + 1'b1 - {1'b0, ramp_end};
      if (state == tsr_pkg::ST_LOAD_CWAIT && ustat.done) begin
        if (max_speed == '0 || uq > W'(PMAX)) held <= PMAX;
        else held <= uq[PERIOD_WIDTH-1:0];
      end
      if (state == tsr_pkg::ST_SQRT_WAIT && ustat.done) begin
        if (ures > W'(PMAX)) held <= PMAX;
        else held <= ures[PERIOD_WIDTH-1:0];
      end
    end
  end
endmodule

>>> rtl/core/three_axis_step_ramp_generator_top.sv
`timescale 1ns / 1ps
// Three-axis step ramp generator.
// Input channel beats carry {req_type, count_x, count_y, count_z, way_x, way_y,
// way_z}, MSB first. A load beat latches a move and yields no result; an
// advance beat yields exactly one result beat {pulse_x, pulse_y, pulse_z,
// dir_out_x, dir_out_y, dir_out_z, period_ticks, last_slot, was_idle}.
// A load keeps the input busy for two divisions in the shared unit plus the
// sequencer steps around them.
// An advance on a ramp slot shows its result after one division and a square
// root on the shared unit.
// A cruise or idle advance shows its result in the cycle after acceptance.
// The block accepts one beat at a time; it is not ready while working or
// while a result waits. When the receiver stalls, the result is held stable.
// Configuration writes use cfg_we, cfg_idx and cfg_data and should only be
// issued while the block is idle. Synchronous reset restores the default
// register values and leaves the block idle with no move active.
module three_axis_step_ramp_generator_top #(
  parameter int STEP_WIDTH = tsr_pkg::STEP_WIDTH_DEF,
  parameter int PERIOD_WIDTH = tsr_pkg::PERIOD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [tsr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tsr_pkg::CFG_DATA_W-1:0] cfg_data,
  tsr_stream_if.sink in_ch,
  tsr_stream_if.source out_ch
);
  // The sequencer holds all move state and drives the shared unit.
  tsr_seq #(.STEP_WIDTH(STEP_WIDTH), .PERIOD_WIDTH(PERIOD_WIDTH)) u_seq (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch));
endmodule

>>> rtl/core/tsr_checker.sv
`timescale 1ns / 1ps
`include "three_axis_step_ramp_generator_top_defines.svh"
module tsr_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_idle,
  input logic [2:0] out_pulses
);
  `TSR_ASSERT_IMP(a_excl, clk, rst, out_valid, !in_ready, "ready while result pending")
  `TSR_ASSERT_IMP(a_idle_np, clk, rst, out_valid && out_idle, out_pulses == 3'b000, "idle pulses")
  `TSR_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
endmodule

bind three_axis_step_ramp_generator_top tsr_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_idle(out_ch.data[0]),
  .out_pulses(out_ch.data[PERIOD_WIDTH+7:PERIOD_WIDTH+5]));
